>>> hw/rtl/hrft_pkg.sv
// types and constants shared by the http request field tagger
package hrft_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;

  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_PATH    = 3'd1,
    KIND_QKEY    = 3'd2,
    KIND_QVAL    = 3'd3,
    KIND_VERSION = 3'd4,
    KIND_HKEY    = 3'd5,
    KIND_HVAL    = 3'd6,
    KIND_BODY    = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      field_kind;
    logic       has_byte;
    logic       field_done;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    res_t first;
    res_t second;
    logic any;
    logic two;
  } pair_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

endpackage

>>> hw/rtl/hrft_in_reg.sv
// input register stage for incoming request bytes
module hrft_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  input  logic              take_i,
  output logic              ready_o,
  output hrft_pkg::in_item_t item_o
);
  import hrft_pkg::*;

  logic       vld_q;
  logic [7:0] byte_q;
  logic       end_q;

  assign ready_o = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= data_i;
      end_q  <= last_i;
    end
  end

  assign item_o.vld         = vld_q;
  assign item_o.data_byte   = byte_q;
  assign item_o.message_end = end_q;

endmodule

>>> hw/rtl/hrft_step.sv
// parse state and per-byte tagging logic
module hrft_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       data_i,
  input  logic             end_i,
  output hrft_pkg::pair_t  pair_o
);
  import hrft_pkg::*;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_PATH    = 4'd1,
    PH_QKEY    = 4'd2,
    PH_QVAL    = 4'd3,
    PH_VERSION = 4'd4,
    PH_HKEY    = 4'd5,
    PH_HVAL    = 4'd6,
    PH_BODY    = 4'd7,
    PH_LINE    = 4'd8
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       held_q, held_d;
  res_t [1:0] r;
  logic [1:0] n;
  kind_e      lk;
  kind_e      ek;

  function automatic res_t mk(input logic [7:0] b, input kind_e k, input logic h,
                              input logic d);
    res_t x;
    x.out_byte    = b;
    x.field_kind  = k;
    x.has_byte    = h;
    x.field_done  = d;
    x.last_of_run = 1'b0;
    return x;
  endfunction

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    n       = 2'd0;
    r       = '0;
    lk      = (phase_q == PH_VERSION) ? KIND_VERSION : KIND_HVAL;
    ek      = KIND_METHOD;
    unique case (phase_q) inside
      PH_PATH: begin
        if (data_i == ChSpace || data_i == ChQuery) begin
          r[n[0]] = mk(8'h00, KIND_PATH, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = (data_i == ChSpace) ? PH_VERSION : PH_QKEY;
        end else begin
          r[n[0]] = mk(data_i, KIND_PATH, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end
      PH_QKEY: begin
        if (data_i == ChEqual) begin
          r[n[0]] = mk(8'h00, KIND_QKEY, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = PH_QVAL;
        end else begin
          r[n[0]] = mk(data_i, KIND_QKEY, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end
      PH_QVAL: begin
        if (data_i == ChSpace || data_i == ChAmp) begin
          r[n[0]] = mk(8'h00, KIND_QVAL, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = (data_i == ChSpace) ? PH_VERSION : PH_QKEY;
        end else begin
          r[n[0]] = mk(data_i, KIND_QVAL, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end
      PH_VERSION, PH_HVAL: begin
        if (held_q && data_i == ChLf) begin
          held_d = 1'b0;
          r[n[0]] = mk(8'h00, lk, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = PH_LINE;
        end else begin
          if (held_q) begin
            r[n[0]] = mk(ChCr, lk, 1'b1, 1'b0);
            n = n + 2'd1;
          end
          if (data_i == ChCr) begin
            held_d = 1'b1;
          end else begin
            held_d = 1'b0;
            r[n[0]] = mk(data_i, lk, 1'b1, 1'b0);
            n = n + 2'd1;
          end
        end
      end
      PH_HKEY: begin
        if (held_q && data_i == ChSpace) begin
          held_d = 1'b0;
          r[n[0]] = mk(8'h00, KIND_HKEY, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = PH_HVAL;
        end else begin
          if (held_q) begin
            r[n[0]] = mk(ChColon, KIND_HKEY, 1'b1, 1'b0);
            n = n + 2'd1;
          end
          if (data_i == ChColon) begin
            held_d = 1'b1;
          end else begin
            held_d = 1'b0;
            r[n[0]] = mk(data_i, KIND_HKEY, 1'b1, 1'b0);
            n = n + 2'd1;
          end
        end
      end
      PH_LINE: begin
        if (held_q && data_i == ChLf) begin
          held_d  = 1'b0;
          phase_d = PH_BODY;
        end else if (!held_q && data_i == ChCr) begin
          held_d = 1'b1;
        end else begin
          phase_d = PH_HKEY;
          if (held_q) begin
            r[n[0]] = mk(ChCr, KIND_HKEY, 1'b1, 1'b0);
            n = n + 2'd1;
          end
          if (data_i == ChColon) begin
            held_d = 1'b1;
          end else begin
            held_d = 1'b0;
            r[n[0]] = mk(data_i, KIND_HKEY, 1'b1, 1'b0);
            n = n + 2'd1;
          end
        end
      end
      PH_BODY: begin
        r[n[0]] = mk(data_i, KIND_BODY, 1'b1, 1'b0);
        n = n + 2'd1;
      end
      default: begin
        if (data_i == ChSpace) begin
          r[n[0]] = mk(8'h00, KIND_METHOD, 1'b0, 1'b1);
          n = n + 2'd1;
          phase_d = PH_PATH;
        end else begin
          r[n[0]] = mk(data_i, KIND_METHOD, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end
    endcase

    if (end_i) begin
      if (held_d) begin
        unique case (phase_d)
          PH_VERSION: ek = KIND_VERSION;
          PH_HVAL:    ek = KIND_HVAL;
          default:    ek = KIND_HKEY;
        endcase
        r[n[0]] = mk((phase_d == PH_HKEY) ? ChColon : ChCr, ek, 1'b1, 1'b0);
        n = n + 2'd1;
      end
      phase_d = PH_METHOD;
      held_d  = 1'b0;
    end

    if (n == 2'd2) begin
      r[1].last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r[0].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
      held_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign pair_o.first  = r[0];
  assign pair_o.second = r[1];
  assign pair_o.any    = (n != 2'd0);
  assign pair_o.two    = (n == 2'd2);

endmodule

>>> hw/rtl/hrft_out_buf.sv
// result register holding up to two results of one item
module hrft_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  hrft_pkg::pair_t pair_i,
  input  logic            ready_i,
  output logic            free_o,
  output logic            valid_o,
  output hrft_pkg::res_t  res_o
);
  import hrft_pkg::*;

  logic vld_q;
  logic two_q;
  res_t r0_q;
  res_t r1_q;

  assign free_o  = !vld_q || (ready_i && !two_q);
  assign valid_o = vld_q;
  assign res_o   = r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      two_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i && pair_i.any;
      two_q <= load_i && pair_i.two;
    end else if (ready_i) begin
      two_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      if (load_i && pair_i.any) begin
        r0_q <= pair_i.first;
        r1_q <= pair_i.second;
      end
    end else if (ready_i) begin
      r0_q <= r1_q;
    end
  end

endmodule

>>> hw/rtl/http_request_field_tagger.sv
// top level of the http request field tagger
//
// channel   dir  tdata           tuser                          tlast
// s_axis    in   data_byte       -                              message_end
// m_axis    out  out_byte        field_kind, has_byte, done     last_of_run
//
// one item per cycle unless stalled; the first result shows in the cycle after taking
// an item with two results holds the result register until both are taken
// an item with no result only advances the parse state
// rst_ni returns the parser to the method phase with nothing held
module http_request_field_tagger (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [7:0] m_axis_tuser,   // [2:0] field_kind, [3] has_byte, [4] field_done
  output logic       m_axis_tlast
);
  import hrft_pkg::*;

  in_item_t item;
  pair_t    pair;
  res_t     res;
  logic     free;
  logic     take;

  assign take = item.vld && free;

  hrft_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .take_i  (take),
    .ready_o (s_axis_tready),
    .item_o  (item)
  );

  hrft_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (take),
    .data_i (item.data_byte),
    .end_i  (item.message_end),
    .pair_o (pair)
  );

  hrft_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .pair_i  (pair),
    .ready_i (m_axis_tready),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tuser = {3'b000, res.field_done, res.has_byte, res.field_kind};
  assign m_axis_tlast = res.last_of_run;

endmodule

>>> hw/rtl/hrft_checker.sv
// port checks for the http request field tagger
module hrft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [7:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import hrft_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_byte_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[3] != m_axis_tuser[4]))
    else $error("result must carry a byte or close a field");

  a_done_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tdata == 8'h00)
    else $error("field end carries data");

  a_body_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:0] == KIND_BODY |-> m_axis_tuser[3])
    else $error("body field closed");

endmodule

bind http_request_field_tagger hrft_checker u_hrft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/testbench.sv
// self-checking bench for the http request field tagger: directed table, then random requests
`timescale 1ns / 1ps

module testbench;
  import hrft_pkg::*;

  localparam int RandomItems = 1650;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 20;

  typedef enum logic [3:0] {
    PH_METHOD, PH_PATH, PH_QKEY, PH_QVAL, PH_VERSION, PH_HKEY, PH_HVAL, PH_BODY, PH_LINE
  } phase_e;

  typedef struct {
    logic [7:0] data_byte;
    logic       msg_end;
    logic       known;
    res_t       want;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [7:0] m_axis_tuser;
  logic       m_axis_tlast;

  phase_e     parse_q = PH_METHOD;
  logic       held_q = 1'b0;
  res_t       run_q[$];
  res_t       expected_q[$];
  row_t       dir_q[$];
  logic [7:0] msg_q[$];
  res_t       got_res;
  res_t       want_res;
  logic       hold_rx = 1'b0;
  int         src_idle = 0;
  int         rx_stall = 0;
  int         sent = 0;
  int         errors = 0;
  int         idle_cycles = 0;

  http_request_field_tagger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void emit_res(input logic [7:0] b, input kind_e k, input logic has,
                                   input logic done);
    res_t r;
    r.out_byte    = b;
    r.field_kind  = k;
    r.has_byte    = has;
    r.field_done  = done;
    r.last_of_run = 1'b0;
    run_q.insert(run_q.size(), r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void hkey_content(input logic [7:0] b);
    if (b == ChColon) held_q = 1'b1;
    else emit_res(b, KIND_HKEY, 1'b1, 1'b0);
  endfunction

  function automatic void line_content(input logic [7:0] b, input kind_e k);
    if (b == ChCr) held_q = 1'b1;
    else emit_res(b, k, 1'b1, 1'b0);
  endfunction

  function automatic void predict_tags(input logic [7:0] b, input logic msg_end);
    phase_e ph;
    kind_e  k;
    res_t   r;
    ph = parse_q;
    k  = kind_e'(ph[2:0]);
    run_q.delete();
    case (ph) inside
      PH_PATH: begin
        if (b == ChSpace || b == ChQuery) begin
          emit_res(8'h00, KIND_PATH, 1'b0, 1'b1);
          ph = (b == ChSpace) ? PH_VERSION : PH_QKEY;
        end else emit_res(b, KIND_PATH, 1'b1, 1'b0);
      end
      PH_QKEY: begin
        if (b == ChEqual) begin
          emit_res(8'h00, KIND_QKEY, 1'b0, 1'b1);
          ph = PH_QVAL;
        end else emit_res(b, KIND_QKEY, 1'b1, 1'b0);
      end
      PH_QVAL: begin
        if (b == ChSpace || b == ChAmp) begin
          emit_res(8'h00, KIND_QVAL, 1'b0, 1'b1);
          ph = (b == ChSpace) ? PH_VERSION : PH_QKEY;
        end else emit_res(b, KIND_QVAL, 1'b1, 1'b0);
      end
      PH_VERSION, PH_HVAL: begin
        if (held_q) begin
          held_q = 1'b0;
          if (b == ChLf) begin
            emit_res(8'h00, k, 1'b0, 1'b1);
            ph = PH_LINE;
          end else begin
            emit_res(ChCr, k, 1'b1, 1'b0);
            line_content(b, k);
          end
        end else line_content(b, k);
      end
      PH_HKEY: begin
        if (held_q) begin
          held_q = 1'b0;
          if (b == ChSpace) begin
            emit_res(8'h00, KIND_HKEY, 1'b0, 1'b1);
            ph = PH_HVAL;
          end else begin
            emit_res(ChColon, KIND_HKEY, 1'b1, 1'b0);
            hkey_content(b);
          end
        end else hkey_content(b);
      end
      PH_LINE: begin
        if (held_q) begin
          held_q = 1'b0;
          if (b == ChLf) begin
            ph = PH_BODY;
          end else begin
            emit_res(ChCr, KIND_HKEY, 1'b1, 1'b0);
            ph = PH_HKEY;
            hkey_content(b);
          end
        end else if (b == ChCr) begin
          held_q = 1'b1;
        end else begin
          ph = PH_HKEY;
          hkey_content(b);
        end
      end
      PH_BODY: emit_res(b, KIND_BODY, 1'b1, 1'b0);
      default: begin
        if (b == ChSpace) begin
          emit_res(8'h00, KIND_METHOD, 1'b0, 1'b1);
          ph = PH_PATH;
        end else emit_res(b, KIND_METHOD, 1'b1, 1'b0);
      end
    endcase
    if (msg_end) begin
      if (held_q) begin
        if (ph == PH_HKEY) emit_res(ChColon, KIND_HKEY, 1'b1, 1'b0);
        else if (ph == PH_LINE) emit_res(ChCr, KIND_HKEY, 1'b1, 1'b0);
        else emit_res(ChCr, kind_e'(ph[2:0]), 1'b1, 1'b0);
      end
      ph     = PH_METHOD;
      held_q = 1'b0;
    end
    parse_q = ph;
    if (run_q.size() > 0) begin
      r = run_q[run_q.size() - 1];
      r.last_of_run = 1'b1;
      run_q[run_q.size() - 1] = r;
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic msg_end);
    row_t row;
    row.data_byte = b;
    row.msg_end   = msg_end;
    row.known     = 1'b0;
    row.want      = '0;
    dir_q.insert(dir_q.size(), row);
  endfunction

  function automatic void add_known(input logic [7:0] b, input logic msg_end, input kind_e k,
                                    input logic has, input logic done);
    row_t row;
    row.data_byte        = b;
    row.msg_end          = msg_end;
    row.known            = 1'b1;
    row.want.out_byte    = has ? b : 8'h00;
    row.want.field_kind  = k;
    row.want.has_byte    = has;
    row.want.field_done  = done;
    row.want.last_of_run = 1'b1;
    dir_q.insert(dir_q.size(), row);
  endfunction

  function automatic logic [7:0] text_byte(input logic [7:0] stray_ch);
    if ($urandom_range(9) == 0) return stray_ch;
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return ChSpace;
      1: return ChQuery;
      2: return ChEqual;
      3: return ChAmp;
      4: return ChCr;
      5: return ChLf;
      6: return ChColon;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void build_msg();
    int n_pairs;
    int cut;
    msg_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat (1 + $urandom_range(15)) put_byte(noise_byte());
      return;
    end
    repeat (1 + $urandom_range(4)) put_byte(text_byte(8'h2F));
    put_byte(ChSpace);
    repeat ($urandom_range(5)) put_byte(text_byte(8'h2F));
    if ($urandom_range(1) == 1) begin
      put_byte(ChQuery);
      n_pairs = 1 + $urandom_range(2);
      for (int p = 0; p < n_pairs; p++) begin
        repeat ($urandom_range(3)) put_byte(text_byte(8'h2F));
        put_byte(ChEqual);
        repeat ($urandom_range(3)) put_byte(text_byte(8'h2F));
        if (p != n_pairs - 1) put_byte(ChAmp);
      end
    end
    put_byte(ChSpace);
    repeat (1 + $urandom_range(5)) put_byte(text_byte(ChCr));
    put_byte(ChCr);
    put_byte(ChLf);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(7) == 0) put_byte(ChCr);
      repeat (1 + $urandom_range(3)) put_byte(text_byte(ChColon));
      put_byte(ChColon);
      put_byte(ChSpace);
      repeat ($urandom_range(5)) put_byte(text_byte(ChCr));
      put_byte(ChCr);
      put_byte(ChLf);
    end
    put_byte(ChCr);
    put_byte(ChLf);
    repeat ($urandom_range(8)) put_byte(8'($urandom_range(255)));
    if ($urandom_range(4) == 0) begin
      cut = 1 + $urandom_range(msg_q.size() - 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic msg_end, input logic known,
                           input res_t want);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= msg_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tags(b, msg_end);
    if (known) expected_q.insert(expected_q.size(), want);
    else foreach (run_q[i]) expected_q.insert(expected_q.size(), run_q[i]);
    sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.out_byte    = m_axis_tdata;
      got_res.field_kind  = kind_e'(m_axis_tuser[2:0]);
      got_res.has_byte    = m_axis_tuser[3];
      got_res.field_done  = m_axis_tuser[4];
      got_res.last_of_run = m_axis_tlast;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: byte %h kind %0d has %b done %b last %b",
                   got_res.out_byte, got_res.field_kind, got_res.has_byte,
                   got_res.field_done, got_res.last_of_run);
      end else begin
        want_res = expected_q.pop_front();
        if (got_res !== want_res) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp byte %h kind %0d has %b done %b last %b / %s",
                     want_res.out_byte, want_res.field_kind, want_res.has_byte,
                     want_res.field_done, want_res.last_of_run,
                     $sformatf("got byte %h kind %0d has %b done %b last %b",
                               got_res.out_byte, got_res.field_kind, got_res.has_byte,
                               got_res.field_done, got_res.last_of_run));
        end
      end
    end
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_stall);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver holds off while the sender keeps offering items
  initial begin
    wait (sent >= 200);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    add_known("G", 1'b0, KIND_METHOD, 1'b1, 1'b0);
    add_known(ChSpace, 1'b0, KIND_METHOD, 1'b0, 1'b1);
    add_known(8'hFF, 1'b0, KIND_PATH, 1'b1, 1'b0);
    add_known(ChQuery, 1'b0, KIND_PATH, 1'b0, 1'b1);
    add_known("k", 1'b0, KIND_QKEY, 1'b1, 1'b0);
    add_known(ChEqual, 1'b0, KIND_QKEY, 1'b0, 1'b1);
    add_known(8'h00, 1'b0, KIND_QVAL, 1'b1, 1'b0);
    add_known(ChAmp, 1'b0, KIND_QVAL, 1'b0, 1'b1);
    add_known(ChEqual, 1'b0, KIND_QKEY, 1'b0, 1'b1);
    add_known(ChSpace, 1'b0, KIND_QVAL, 1'b0, 1'b1);
    add_known("H", 1'b0, KIND_VERSION, 1'b1, 1'b0);
    // held cr not confirmed, then a real line end
    add_row(ChCr, 1'b0);
    add_row("x", 1'b0);
    add_row(ChCr, 1'b0);
    add_row(ChLf, 1'b0);
    add_known("K", 1'b0, KIND_HKEY, 1'b1, 1'b0);
    // held colon not confirmed, then a real key end
    add_row(ChColon, 1'b0);
    add_row("z", 1'b0);
    add_row(ChColon, 1'b0);
    add_row(ChSpace, 1'b0);
    add_row(ChCr, 1'b0);
    add_row(ChLf, 1'b0);
    // cr at line start without lf becomes key content
    add_row(ChCr, 1'b0);
    add_row("q", 1'b0);
    add_row(ChColon, 1'b0);
    add_row(ChSpace, 1'b0);
    add_row(ChCr, 1'b0);
    add_row(ChLf, 1'b0);
    // blank line enters the body
    add_row(ChCr, 1'b0);
    add_row(ChLf, 1'b0);
    add_known(ChCr, 1'b0, KIND_BODY, 1'b1, 1'b0);
    add_known(8'hFF, 1'b1, KIND_BODY, 1'b1, 1'b0);
    // message end with a cr still held
    add_row("M", 1'b0);
    add_row(ChSpace, 1'b0);
    add_row(ChSpace, 1'b0);
    add_row(ChCr, 1'b1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i])
      send_byte(dir_q[i].data_byte, dir_q[i].msg_end, dir_q[i].known, dir_q[i].want);

    sent = 0;
    while (sent < RandomItems) begin
      if (sent < 450) begin
        src_idle = 0;
        rx_stall = 0;
      end else if (sent < 850) begin
        src_idle = 66;
        rx_stall = 0;
      end else if (sent < 1250) begin
        src_idle = 0;
        rx_stall = 66;
      end else begin
        src_idle = 28;
        rx_stall = 28;
      end
      build_msg();
      foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    rx_stall = 0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
